// ===== rtl/core/onewire_bus_master_core_macros.svh =====
// ----------------------------------------------------------------------------
// 1-Wire master assertion macros
// Shared property forms for the checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_BUS_MASTER_CORE_MACROS_SVH
`define ONEWIRE_BUS_MASTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("onewire check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("onewire check failed");

`endif

// ===== rtl/core/ow_pkg.sv =====
// ----------------------------------------------------------------------------
// 1-Wire master package
// Phase encoding, command codes and the state and result records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ow_pkg;

	// Command codes carried on the input beat.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_RESET = 2'd1;
	localparam logic [1:0] CMD_SEND  = 2'd2;
	localparam logic [1:0] CMD_RECV  = 2'd3;

	// Timing register indexes.
	localparam int NUM_REGS = 8;
	localparam logic [3:0] REG_RESET_LOW    = 4'd0;
	localparam logic [3:0] REG_PRES_WAIT    = 4'd1;
	localparam logic [3:0] REG_RESET_REC    = 4'd2;
	localparam logic [3:0] REG_WRITE_LOW    = 4'd3;
	localparam logic [3:0] REG_WRITE_HOLD   = 4'd4;
	localparam logic [3:0] REG_READ_LOW     = 4'd5;
	localparam logic [3:0] REG_READ_SAMPLE  = 4'd6;
	localparam logic [3:0] REG_READ_RECOVER = 4'd7;

	typedef logic [9:0] tval_t;
	typedef tval_t [NUM_REGS-1:0] timing_t;

	// Reset values of the timing registers, in microsecond ticks.
	localparam timing_t TIMING_RESET = {
		10'd50, 10'd5, 10'd5, 10'd50, 10'd10, 10'd500, 10'd70, 10'd500
	};

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_RST_LOW = 4'd1,
		PH_RST_WT  = 4'd2,
		PH_RST_REC = 4'd3,
		PH_WR_LOW  = 4'd4,
		PH_WR_HOLD = 4'd5,
		PH_RD_LOW  = 4'd6,
		PH_RD_WT   = 4'd7,
		PH_RD_REC  = 4'd8
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [1:0] op_kind;
		tval_t      slot_timer;
		logic [2:0] bit_index;
		logic [7:0] shift_reg;
		logic       presence;
	} ow_state_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence_bit;
		logic [7:0] byte_out;
		logic       cmd_rejected;
	} ow_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ow_step.sv =====
// ----------------------------------------------------------------------------
// 1-Wire master tick step
// Next-state and result logic for one microsecond tick of bus timing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ow_step (
	input  wire ow_pkg::ow_state_t  cur,
	input  wire ow_pkg::timing_t    timing,
	input  wire logic [1:0]         cmd,
	input  wire logic [7:0]         byte_in,
	input  wire logic               line_level,
	output ow_pkg::ow_state_t       nxt,
	output ow_pkg::ow_result_t      res
);

	// Length of a phase in ticks; a zero register counts as one tick.
	function automatic ow_pkg::tval_t phase_len(input ow_pkg::phase_t ph,
			input ow_pkg::timing_t t);
		ow_pkg::tval_t v;
		begin
			unique case (ph)
				ow_pkg::PH_RST_LOW: v = t[ow_pkg::REG_RESET_LOW[2:0]];
				ow_pkg::PH_RST_WT:  v = t[ow_pkg::REG_PRES_WAIT[2:0]];
				ow_pkg::PH_RST_REC: v = t[ow_pkg::REG_RESET_REC[2:0]];
				ow_pkg::PH_WR_LOW:  v = t[ow_pkg::REG_WRITE_LOW[2:0]];
				ow_pkg::PH_WR_HOLD: v = t[ow_pkg::REG_WRITE_HOLD[2:0]];
				ow_pkg::PH_RD_LOW:  v = t[ow_pkg::REG_READ_LOW[2:0]];
				ow_pkg::PH_RD_WT:   v = t[ow_pkg::REG_READ_SAMPLE[2:0]];
				ow_pkg::PH_RD_REC:  v = t[ow_pkg::REG_READ_RECOVER[2:0]];
				default:            v = 10'd1;
			endcase
			phase_len = (v == 10'd0) ? 10'd1 : v;
		end
	endfunction

	always_comb begin
		ow_pkg::ow_state_t s;
		logic       slot_end;
		logic       cur_bit;
		ow_pkg::phase_t ph_next;
		s = cur;
		slot_end = 1'b0;
		cur_bit = 1'b0;
		ph_next = ow_pkg::PH_IDLE;
		res = '0;

		// Command intake: start an operation when idle, flag it when busy.
		if (s.phase != ow_pkg::PH_IDLE) begin
			res.cmd_rejected = (cmd != ow_pkg::CMD_TICK);
		end else if (cmd != ow_pkg::CMD_TICK) begin
			s.op_kind = cmd;
			s.bit_index = 3'd0;
			case (cmd)
				ow_pkg::CMD_RESET: s.phase = ow_pkg::PH_RST_LOW;
				ow_pkg::CMD_SEND: begin
					s.shift_reg = byte_in;
					s.phase = ow_pkg::PH_WR_LOW;
				end
				default: begin
					s.shift_reg = 8'd0;
					s.phase = ow_pkg::PH_RD_LOW;
				end
			endcase
			s.slot_timer = phase_len(s.phase, timing);
		end

		// Bus drive and timer for the active phase.
		if (s.phase != ow_pkg::PH_IDLE) begin
			cur_bit = s.shift_reg[s.bit_index];
			unique case (s.phase) inside
				ow_pkg::PH_RST_LOW, ow_pkg::PH_WR_LOW, ow_pkg::PH_RD_LOW:
					res.drive_low = 1'b1;
				ow_pkg::PH_WR_HOLD: res.drive_low = ~cur_bit;
				default:            res.drive_low = 1'b0;
			endcase

			s.slot_timer = s.slot_timer - 10'd1;
			if (s.slot_timer == 10'd0) begin
				unique case (s.phase) inside
					ow_pkg::PH_RST_LOW: ph_next = ow_pkg::PH_RST_WT;
					ow_pkg::PH_RST_WT: begin
						s.presence = line_level;
						ph_next = ow_pkg::PH_RST_REC;
					end
					ow_pkg::PH_WR_LOW: ph_next = ow_pkg::PH_WR_HOLD;
					ow_pkg::PH_RD_LOW: ph_next = ow_pkg::PH_RD_WT;
					ow_pkg::PH_RD_WT: begin
						if (line_level) begin
							s.shift_reg[s.bit_index] = 1'b1;
						end
						ph_next = ow_pkg::PH_RD_REC;
					end
					ow_pkg::PH_WR_HOLD, ow_pkg::PH_RD_REC: slot_end = 1'b1;
					default: begin
						// Reset recovery ends the operation.
						res.done_res = (s.phase == ow_pkg::PH_RST_REC);
						ph_next = ow_pkg::PH_IDLE;
					end
				endcase

				// Next bit slot, or the end of the byte.
				if (slot_end) begin
					if (s.bit_index == 3'd7) begin
						ph_next = ow_pkg::PH_IDLE;
						res.done_res = 1'b1;
						if (s.op_kind == ow_pkg::CMD_RECV) begin
							res.byte_out = s.shift_reg;
						end
						s.bit_index = 3'd0;
					end else begin
						s.bit_index = s.bit_index + 3'd1;
						ph_next = (s.op_kind == ow_pkg::CMD_SEND) ?
							ow_pkg::PH_WR_LOW : ow_pkg::PH_RD_LOW;
					end
				end

				s.phase = ph_next;
				if (ph_next != ow_pkg::PH_IDLE) begin
					s.slot_timer = phase_len(ph_next, timing);
				end
			end
		end

		res.busy_res = (s.phase != ow_pkg::PH_IDLE);
		res.presence_bit = s.presence;
		nxt = s;
	end

endmodule

`default_nettype wire

// ===== rtl/core/onewire_bus_master_core.sv =====
// One-wire bus master core. Every input beat is one microsecond tick carrying
// the sampled bus level and an optional command (reset with presence detect,
// send a byte, receive a byte, least significant bit first), and every tick
// yields exactly one result beat with the open-drain drive, busy, done,
// presence, received byte and a reject flag for commands given while busy.
// A beat is taken on every clock that the sink's tready allows: it passes an input
// register, the tick logic and a result register, and throughput is one beat per
// cycle, set only by the sink's tready. Slot timings are eight 10-bit registers
// on the cfg port, which the user must write only while the core is idle; the core does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

`include "onewire_bus_master_core_macros.svh"

// ----------------------------------------------------------------------------
// 1-Wire bus master core
// Input register, tick step logic, result register and timing registers.
// ----------------------------------------------------------------------------
module onewire_bus_master_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input beats.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [7:0] byte_in, [8] line_level, rest zero
	input  wire logic [1:0]  s_tuser,   // [1:0] cmd
	// Result beats.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
	                                    // [3] presence_bit, [11:4] byte_out,
	                                    // [12] cmd_rejected, rest zero
	// Timing register writes.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [9:0]  cfg_data
);

	logic               valid_s1;
	logic [1:0]         cmd_s1;
	logic [7:0]         byte_s1;
	logic               level_s1;
	logic               advance;
	logic               out_valid_q;
	ow_pkg::ow_result_t out_q;
	ow_pkg::ow_state_t  state_q;
	ow_pkg::ow_state_t  state_nxt;
	ow_pkg::ow_result_t res_nxt;
	ow_pkg::timing_t    timing_q;

	// The held beat moves on when the result register is free or being taken.
	assign advance   = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready  = ~valid_s1 | advance;
	assign cfg_ready = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1   <= s_tuser;
			byte_s1  <= s_tdata[7:0];
			level_s1 <= s_tdata[8];
		end
	end

	// Timing registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q <= ow_pkg::TIMING_RESET;
		end else if (cfg_valid && cfg_index <= ow_pkg::REG_READ_RECOVER) begin
			timing_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// Tick step logic.
	ow_step u_step (
		.cur        (state_q),
		.timing     (timing_q),
		.cmd        (cmd_s1),
		.byte_in    (byte_s1),
		.line_level (level_s1),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// Bus state, updated once per processed tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= ow_pkg::PH_IDLE;
			state_q.op_kind    <= 2'd0;
			state_q.slot_timer <= 10'd0;
			state_q.bit_index  <= 3'd0;
			state_q.shift_reg  <= 8'd0;
			state_q.presence   <= 1'b1;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_q.cmd_rejected, out_q.byte_out, out_q.presence_bit,
		out_q.done_res, out_q.busy_res, out_q.drive_low};

	// Checks on the core's own bookkeeping.
	`OW_ASSERT_NOW(a_timer_live, clk, arst_n, state_q.phase != ow_pkg::PH_IDLE,
		state_q.slot_timer != 10'd0)
	`OW_ASSERT_NOW(a_done_not_busy, clk, arst_n, out_valid_q && out_q.done_res,
		!out_q.busy_res)
	`OW_ASSERT_NOW(a_byte_on_done, clk, arst_n, out_valid_q && out_q.byte_out != 8'd0,
		out_q.done_res)
	`OW_ASSERT_NEXT(a_advance_result, clk, arst_n, advance, out_valid_q)

endmodule

`default_nettype wire
